>>> rtl/email_token_extractor_defines.svh
// ----------------------------------------------------------------------------
// Email token extractor assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef EMAIL_TOKEN_EXTRACTOR_DEFINES_SVH
`define EMAIL_TOKEN_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ETX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ETX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/etx_pkg.sv
// ----------------------------------------------------------------------------
// Email token extractor package
// Sizes, character codes and the run descriptor used across the extractor.
// ----------------------------------------------------------------------------
package etx_pkg;

  localparam int MaxRunLen = 64;
  localparam int IdxW      = $clog2(MaxRunLen);
  localparam int LenW      = $clog2(MaxRunLen + 1);
  localparam int RamDepth  = 2 ** (IdxW + 1);
  localparam int RamAddrW  = IdxW + 1;

  localparam int AtMax  = 64;
  localparam int AtW    = 7;
  localparam int NumW   = 16;
  localparam int CharW  = 8;

  localparam logic [CharW-1:0] ChNewline = 8'h0A;
  localparam logic [CharW-1:0] ChAt      = 8'h40;
  localparam logic [CharW-1:0] ChDot     = 8'h2E;
  localparam logic [CharW-1:0] ChDash    = 8'h2D;
  localparam logic [CharW-1:0] ChPlus    = 8'h2B;
  localparam logic [CharW-1:0] ChUpperA  = 8'h41;
  localparam logic [CharW-1:0] ChUpperZ  = 8'h5A;
  localparam logic [CharW-1:0] ChLowerA  = 8'h61;
  localparam logic [CharW-1:0] ChLowerZ  = 8'h7A;
  localparam logic [CharW-1:0] ChDigit0  = 8'h30;
  localparam logic [CharW-1:0] ChDigit9  = 8'h39;

  // One finished run waiting for readout
  typedef struct packed {
    logic            bank;
    logic [LenW-1:0] len;
    logic [NumW-1:0] number;
    logic [AtW-1:0]  at_count;
    logic            truncated;
  } etx_desc_t;

  typedef enum logic {
    BackIdle,
    BackRead
  } etx_back_e;

endpackage

>>> rtl/etx_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module etx_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/etx_front.sv
// ----------------------------------------------------------------------------
// Email token extractor front end
// Classifies bytes, builds runs in a ping-pong buffer, queues finished runs.
// ----------------------------------------------------------------------------
module etx_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [etx_pkg::CharW-1:0]     text_byte_i,
  input  logic                          end_of_input_i,
  output logic                          ram_we_o,
  output logic [etx_pkg::RamAddrW-1:0]  ram_waddr_o,
  output logic [etx_pkg::CharW-1:0]     ram_wdata_o,
  output logic                          desc_push_o,
  output etx_pkg::etx_desc_t            desc_o,
  input  logic                          release_i
);

  logic                          skip_q, skip_d;
  logic                          hdr_q, hdr_d;
  logic                          bank_q, bank_d;
  logic [etx_pkg::LenW-1:0]      run_len_q, run_len_d;
  logic [etx_pkg::AtW-1:0]       at_cnt_q, at_cnt_d;
  logic                          ovf_q, ovf_d;
  logic [etx_pkg::NumW-1:0]      seen_q, seen_d;
  logic [1:0]                    held_q, held_d;

  logic                          accept, skipped, addr_char, store, store_wr, flush, emit;
  logic [etx_pkg::LenW-1:0]      len_n;
  logic [etx_pkg::AtW-1:0]       at_n;
  logic                          ovf_n;
  logic [etx_pkg::NumW-1:0]      number;
  logic [etx_pkg::NumW:0]        seen_sum;

  function automatic logic is_addr_char(input logic [etx_pkg::CharW-1:0] b);
    logic r;
    r = ((b >= etx_pkg::ChUpperA) && (b <= etx_pkg::ChUpperZ)) ||
        ((b >= etx_pkg::ChLowerA) && (b <= etx_pkg::ChLowerZ)) ||
        ((b >= etx_pkg::ChDigit0) && (b <= etx_pkg::ChDigit9)) ||
        (b == etx_pkg::ChDot) || (b == etx_pkg::ChDash) ||
        (b == etx_pkg::ChPlus) || (b == etx_pkg::ChAt);
    return r;
  endfunction

  // both buffer banks owned by pending runs
  assign full_o    = (held_q == 2'd2);
  assign accept    = push_i & ~full_o;
  assign skipped   = hdr_q & skip_q;
  assign addr_char = is_addr_char(text_byte_i);
  assign store     = ~skipped & addr_char;
  assign store_wr  = store & (run_len_q < etx_pkg::LenW'(etx_pkg::MaxRunLen));

  assign len_n = store_wr ? run_len_q + etx_pkg::LenW'(1) : run_len_q;
  assign ovf_n = ovf_q | (store & ~store_wr);
  assign at_n  = (store && (text_byte_i == etx_pkg::ChAt) &&
                  (at_cnt_q < etx_pkg::AtW'(etx_pkg::AtMax))) ?
                 at_cnt_q + etx_pkg::AtW'(1) : at_cnt_q;

  assign flush = (~skipped & ~addr_char) | end_of_input_i;
  assign emit  = flush && (at_n != '0) && (len_n != '0);

  assign number   = (seen_q == '1) ? seen_q : seen_q + etx_pkg::NumW'(1);
  assign seen_sum = {1'b0, seen_q} + (etx_pkg::NumW + 1)'(at_n);

  assign ram_we_o    = accept & store_wr;
  assign ram_waddr_o = {bank_q, run_len_q[etx_pkg::IdxW-1:0]};
  assign ram_wdata_o = text_byte_i;

  assign desc_push_o        = accept & emit;
  assign desc_o.bank        = bank_q;
  assign desc_o.len         = len_n;
  assign desc_o.number      = number;
  assign desc_o.at_count    = at_n;
  assign desc_o.truncated   = ovf_n;

  always_comb begin
    skip_d    = cfg_we_i ? cfg_wdata_i : skip_q;
    hdr_d     = hdr_q;
    bank_d    = bank_q;
    run_len_d = run_len_q;
    at_cnt_d  = at_cnt_q;
    ovf_d     = ovf_q;
    seen_d    = seen_q;
    if (accept) begin
      if (text_byte_i == etx_pkg::ChNewline) begin
        hdr_d = 1'b0;
      end
      if (flush) begin
        run_len_d = '0;
        at_cnt_d  = '0;
        ovf_d     = 1'b0;
        if (emit) begin
          bank_d = ~bank_q;
          seen_d = seen_sum[etx_pkg::NumW] ? '1 : seen_sum[etx_pkg::NumW-1:0];
        end
      end else begin
        run_len_d = len_n;
        at_cnt_d  = at_n;
        ovf_d     = ovf_n;
      end
    end
    held_d = held_q + 2'(desc_push_o) - 2'(release_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q    <= 1'b1;
      hdr_q     <= 1'b1;
      bank_q    <= 1'b0;
      run_len_q <= '0;
      at_cnt_q  <= '0;
      ovf_q     <= 1'b0;
      seen_q    <= '0;
      held_q    <= '0;
    end else begin
      skip_q    <= skip_d;
      hdr_q     <= hdr_d;
      bank_q    <= bank_d;
      run_len_q <= run_len_d;
      at_cnt_q  <= at_cnt_d;
      ovf_q     <= ovf_d;
      seen_q    <= seen_d;
      held_q    <= held_d;
    end
  end

endmodule

>>> rtl/etx_desc_fifo.sv
// ----------------------------------------------------------------------------
// Email token extractor run queue
// Two-entry queue of run descriptors between front and back end.
// ----------------------------------------------------------------------------
module etx_desc_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  etx_pkg::etx_desc_t wdata_i,
  input  logic               pop_i,
  output logic               empty_o,
  output etx_pkg::etx_desc_t rdata_o
);

  etx_pkg::etx_desc_t entry_q [2];
  logic               wptr_q, wptr_d;
  logic               rptr_q, rptr_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               do_pop;

  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = entry_q[rptr_q];
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> rtl/etx_back.sv
// ----------------------------------------------------------------------------
// Email token extractor back end
// Reads a finished run out of the buffer into the result register.
// ----------------------------------------------------------------------------
module etx_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          desc_empty_i,
  input  etx_pkg::etx_desc_t            desc_i,
  output logic                          desc_pop_o,
  output logic                          ram_re_o,
  output logic [etx_pkg::RamAddrW-1:0]  ram_raddr_o,
  input  logic [etx_pkg::CharW-1:0]     ram_rdata_i,
  output logic                          release_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [etx_pkg::CharW-1:0]     email_char_o,
  output logic                          last_char_o,
  output logic [etx_pkg::NumW-1:0]      email_number_o,
  output logic [etx_pkg::AtW-1:0]       repeat_count_o,
  output logic                          truncated_o
);

  etx_pkg::etx_back_e       state_q, state_d;
  etx_pkg::etx_desc_t       desc_q;
  logic [etx_pkg::LenW-1:0] k_q, k_d;
  logic                     rd_pend_q, rd_last_q;
  logic                     out_v_q, out_v_d;
  logic [etx_pkg::CharW-1:0] out_char_q;
  logic                     out_last_q;
  logic [etx_pkg::NumW-1:0] out_num_q;
  logic [etx_pkg::AtW-1:0]  out_cnt_q;
  logic                     out_trunc_q;

  logic pop_fire, issue, last_issue, load_desc;

  assign pop_fire   = pop_i & out_v_q;
  assign last_issue = (k_q == desc_q.len - etx_pkg::LenW'(1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      etx_pkg::BackIdle: begin
        if (!desc_empty_i) state_d = etx_pkg::BackRead;
      end
      etx_pkg::BackRead: begin
        if (issue && last_issue) state_d = etx_pkg::BackIdle;
      end
      default: state_d = etx_pkg::BackIdle;
    endcase
  end

  // outputs
  always_comb begin
    load_desc = 1'b0;
    issue     = 1'b0;
    unique case (state_q)
      etx_pkg::BackIdle: begin
        load_desc = ~desc_empty_i;
      end
      etx_pkg::BackRead: begin
        // read data lands in the next cycle; result register must be free by then
        issue = ~rd_pend_q & (~out_v_q | pop_fire);
      end
      default: ;
    endcase
  end

  assign desc_pop_o  = load_desc;
  assign ram_re_o    = issue;
  assign ram_raddr_o = {desc_q.bank, k_q[etx_pkg::IdxW-1:0]};
  assign release_o   = issue & last_issue;

  always_comb begin
    k_d = k_q;
    if (load_desc) begin
      k_d = '0;
    end else if (issue) begin
      k_d = k_q + etx_pkg::LenW'(1);
    end
    out_v_d = out_v_q;
    if (rd_pend_q) begin
      out_v_d = 1'b1;
    end else if (pop_fire) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_desc) begin
      desc_q <= desc_i;
    end
    if (rd_pend_q) begin
      out_char_q  <= ram_rdata_i;
      out_last_q  <= rd_last_q;
      out_num_q   <= desc_q.number;
      out_cnt_q   <= desc_q.at_count;
      out_trunc_q <= desc_q.truncated;
    end
    if (issue) begin
      rd_last_q <= last_issue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= etx_pkg::BackIdle;
      k_q       <= '0;
      rd_pend_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      rd_pend_q <= issue;
      out_v_q   <= out_v_d;
    end
  end

  assign empty_o        = ~out_v_q;
  assign email_char_o   = out_char_q;
  assign last_char_o    = out_last_q;
  assign email_number_o = out_num_q;
  assign repeat_count_o = out_cnt_q;
  assign truncated_o    = out_trunc_q;

endmodule

>>> rtl/email_token_extractor.sv
// ----------------------------------------------------------------------------
// Email token extractor
// Finds runs of address characters holding '@' and streams them out.
// ----------------------------------------------------------------------------
// Input: one byte per cycle while full is low; full rises only while two
// finished runs still hold both halves of the ping-pong run buffer.
// Output: the first character reaches the result ports through the descriptor
// queue, the back end's descriptor register, the registered buffer read and the
// result register; each buffer read waits for the previous one to land.
// Reset: asynchronous, clears control state; buffer contents are not cleared.
module email_token_extractor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  input  logic                       push,
  output logic                       full,
  input  logic [etx_pkg::CharW-1:0]  text_byte_i,
  input  logic                       end_of_input_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [etx_pkg::CharW-1:0]  email_char_o,
  output logic                       last_char_o,
  output logic [etx_pkg::NumW-1:0]   email_number_o,
  output logic [etx_pkg::AtW-1:0]    repeat_count_o,
  output logic                       truncated_o
);

  logic                          ram_we, ram_re;
  logic [etx_pkg::RamAddrW-1:0]  ram_waddr, ram_raddr;
  logic [etx_pkg::CharW-1:0]     ram_wdata, ram_rdata;
  logic                          desc_push, desc_pop, desc_empty, run_release;
  etx_pkg::etx_desc_t            desc_in, desc_out;

  etx_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push_i         (push),
    .full_o         (full),
    .text_byte_i    (text_byte_i),
    .end_of_input_i (end_of_input_i),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .desc_push_o    (desc_push),
    .desc_o         (desc_in),
    .release_i      (run_release)
  );

  etx_ram #(
    .Width (etx_pkg::CharW),
    .Depth (etx_pkg::RamDepth)
  ) u_run_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  etx_desc_fifo u_desc_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .wdata_i (desc_in),
    .pop_i   (desc_pop),
    .empty_o (desc_empty),
    .rdata_o (desc_out)
  );

  etx_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .desc_empty_i   (desc_empty),
    .desc_i         (desc_out),
    .desc_pop_o     (desc_pop),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .release_o      (run_release),
    .empty_o        (empty),
    .pop_i          (pop),
    .email_char_o   (email_char_o),
    .last_char_o    (last_char_o),
    .email_number_o (email_number_o),
    .repeat_count_o (repeat_count_o),
    .truncated_o    (truncated_o)
  );

endmodule

>>> rtl/etx_checker.sv
// ----------------------------------------------------------------------------
// Email token extractor port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "email_token_extractor_defines.svh"

module etx_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  input  logic                       push,
  input  logic                       full,
  input  logic [etx_pkg::CharW-1:0]  text_byte_i,
  input  logic                       end_of_input_i,
  input  logic                       empty,
  input  logic                       pop,
  input  logic [etx_pkg::CharW-1:0]  email_char_o,
  input  logic                       last_char_o,
  input  logic [etx_pkg::NumW-1:0]   email_number_o,
  input  logic [etx_pkg::AtW-1:0]    repeat_count_o,
  input  logic                       truncated_o
);

  `ETX_ASSERT_IMPL(a_count_range, clk_i, rst_ni, !empty, (repeat_count_o != '0) && (repeat_count_o <= etx_pkg::AtW'(etx_pkg::AtMax)), "repeat count out of range")
  `ETX_ASSERT_IMPL(a_number_nonzero, clk_i, rst_ni, !empty, email_number_o != '0, "email number is zero")
  `ETX_ASSERT_NEXT(a_result_stays, clk_i, rst_ni, !empty && !pop, !empty, "result dropped without pop")
  `ETX_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, !empty && !pop, $stable(email_char_o) && $stable(last_char_o) && $stable(email_number_o) && $stable(repeat_count_o) && $stable(truncated_o), "stalled result changed")

endmodule

bind email_token_extractor etx_checker u_etx_checker (.*);
